// ===== rtl/usrfi_pkg.sv =====
package usrfi_pkg;

	localparam logic [1:0] ACT_UPLINK = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [1:0] SEL_ANY   = 2'd0;
	localparam logic [1:0] SEL_PROTO = 2'd1;
	localparam logic [1:0] SEL_NODE  = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EXHAUST = 2'd1;
	localparam logic [1:0] STAT_FAIL    = 2'd2;

	localparam logic [7:0] SYNC_MESH    = 8'h2B;
	localparam logic [7:0] SYNC_MC      = 8'h12;
	localparam logic [7:0] SYNC_RNS     = 8'h42;
	localparam logic [7:0] SYNC_LORAWAN = 8'h34;

	localparam logic [2:0] PCODE_MESH    = 3'd0;
	localparam logic [2:0] PCODE_MC      = 3'd1;
	localparam logic [2:0] PCODE_RNS     = 3'd2;
	localparam logic [2:0] PCODE_LORAWAN = 3'd3;
	localparam logic [2:0] PCODE_CUSTOM  = 3'd4;

	localparam logic [15:0] RESERVE_BLOCK_RESET = 16'd64;

	typedef struct packed {
		logic        used;
		logic [1:0]  selector;
		logic [31:0] match;
		logic [31:0] address;
		logic [7:0]  port;
		logic [31:0] counter;
		logic [31:0] reserved;
	} slot_entry_t;

	typedef struct packed {
		logic node;
		logic proto;
		logic any;
	} slot_hits_t;

	function automatic logic [2:0] proto_code(input logic [7:0] sync);
		logic [2:0] code;
		case (sync)
			SYNC_MESH:    code = PCODE_MESH;
			SYNC_MC:      code = PCODE_MC;
			SYNC_RNS:     code = PCODE_RNS;
			SYNC_LORAWAN: code = PCODE_LORAWAN;
			default:      code = PCODE_CUSTOM;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/usrfi_slot_mem.sv =====
module usrfi_slot_mem
	import usrfi_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output slot_entry_t   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_valid,
	input  slot_entry_t   wr_data
);

	slot_entry_t         mem_q [DEPTH];
	logic [DEPTH-1:0]    valid_q;
	slot_entry_t         rdata_q;
	logic                rvalid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// an entry never written since reset or last clear reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= wr_valid;
			end
			if (rd_en) begin
				rvalid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/usrfi_match_unit.sv =====
module usrfi_match_unit
	import usrfi_pkg::*;
(
	input  slot_entry_t entry,
	input  logic [2:0]  code,
	input  logic [31:0] source_id,
	output slot_hits_t  hits
);

	logic live;

	assign live = entry.used && (entry.address != 32'd0);

	always_comb begin
		hits = '0;
		case (entry.selector)
			SEL_NODE:  hits.node  = live && (code == PCODE_MESH) && (source_id == entry.match);
			SEL_PROTO: hits.proto = live && ({5'd0, code} == entry.match[7:0]);
			SEL_ANY:   hits.any   = live;
			default:   hits = '0;
		endcase
	end

endmodule

// ===== rtl/uplink_slot_resolver_fcnt_issuer_unit.sv =====
// Slot resolver and frame-counter issuer. Pulse start while busy is low to
// hand over one transaction; the result appears for exactly one cycle with
// done high and must be taken then, since the receiver cannot stall. The slot
// table sits in a single-port-read memory that one compare unit walks one slot
// per cycle, and one 33-bit adder serves both the reservation step and the
// counter increment. An ignored or out-of-range action goes straight to done,
// a clear writes the slot, a write reads the slot and then updates it, and an
// uplink scans every slot, picks the best match and, if there is one, runs the
// reservation step and issues a counter unless it ends exhausted or with a
// failed store. The block accepts the next transaction the cycle after done.
module uplink_slot_resolver_fcnt_issuer_unit
	import usrfi_pkg::*;
#(
	parameter int SLOT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  sync_word,
	input  logic [31:0] source_id,
	input  logic        store_ok,
	input  logic [2:0]  slot,
	input  logic        entry_in_use,
	input  logic [1:0]  entry_selector,
	input  logic [31:0] entry_match,
	input  logic [31:0] entry_address,
	input  logic [7:0]  entry_port,
	input  logic [31:0] seed_count,
	output logic        done,
	output logic        matched,
	output logic [2:0]  slot_index,
	output logic [31:0] device_address,
	output logic [7:0]  port,
	output logic [31:0] frame_count,
	output logic [1:0]  count_status,
	output logic        persist_request,
	output logic [31:0] persist_value
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CLEAR  = 4'd1;
	localparam logic [3:0] ST_WR_RD  = 4'd2;
	localparam logic [3:0] ST_WR_UPD = 4'd3;
	localparam logic [3:0] ST_SCAN   = 4'd4;
	localparam logic [3:0] ST_SCAN_E = 4'd5;
	localparam logic [3:0] ST_PICK   = 4'd6;
	localparam logic [3:0] ST_CALC   = 4'd7;
	localparam logic [3:0] ST_ISSUE  = 4'd8;
	localparam logic [3:0] ST_DONE   = 4'd9;

	logic [3:0]  state_q;
	logic [15:0] reserve_block_q;

	// transaction latched at accept
	logic [2:0]    code_q;
	logic [31:0]   src_q;
	logic          store_ok_q;
	logic [SW-1:0] slot_q;
	slot_entry_t   entry_q;
	logic [31:0]   seed_q;

	logic [SW-1:0] idx_q;
	logic          chk_s1;
	logic [SW-1:0] cidx_s1;
	slot_hits_t    found_q;
	logic [SW-1:0] node_idx_q;
	logic [SW-1:0] proto_idx_q;
	logic [SW-1:0] any_idx_q;
	logic [SW-1:0] sel_q;
	logic [31:0]   new_res_q;

	logic          accept;
	logic          cfg_wr;
	logic          slot_ok;
	logic          rd_en;
	logic [SW-1:0] rd_addr;
	slot_entry_t   rd_data;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	logic          wr_valid;
	slot_entry_t   wr_data;
	slot_hits_t    hits;
	logic          any_found;
	logic [SW-1:0] best_idx;
	logic          ge;
	logic [31:0]   add_b;
	logic [32:0]   sum;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = paddr[2] ? 32'd0 : {16'd0, reserve_block_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserve_block_q <= RESERVE_BLOCK_RESET;
		end else if (cfg_wr && !paddr[2]) begin
			reserve_block_q <= pwdata[15:0];
		end
	end

	assign busy    = (state_q != ST_IDLE);
	assign done    = (state_q == ST_DONE);
	assign accept  = start && !busy;
	assign slot_ok = (int'(slot) < SLOT_COUNT);

	usrfi_slot_mem #(
		.DEPTH (SLOT_COUNT),
		.AW    (SW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_valid (wr_valid),
		.wr_data  (wr_data)
	);

	usrfi_match_unit u_match (
		.entry     (rd_data),
		.code      (code_q),
		.source_id (src_q),
		.hits      (hits)
	);

	assign any_found = found_q.node || found_q.proto || found_q.any;
	assign best_idx  = found_q.node  ? node_idx_q :
	                   found_q.proto ? proto_idx_q : any_idx_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_WR_RD: begin
				rd_en   = 1'b1;
				rd_addr = slot_q;
			end
			ST_PICK: begin
				rd_en   = any_found;
				rd_addr = best_idx;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// shared adder: counter + 1 + block in the reservation step, counter + 1 at issue
	assign ge    = (rd_data.counter >= rd_data.reserved);
	assign add_b = (state_q == ST_CALC) ? {16'd0, reserve_block_q} : 32'd0;
	assign sum   = {1'b0, rd_data.counter} + {1'b0, add_b} + 33'd1;

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = slot_q;
		wr_valid = 1'b1;
		wr_data  = entry_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en    = 1'b1;
				wr_valid = 1'b0;
			end
			ST_WR_UPD: begin
				wr_en = 1'b1;
				if (entry_q.address != rd_data.address) begin
					wr_data.counter  = (entry_q.address == 32'd0) ? 32'd0 : seed_q;
					wr_data.reserved = (entry_q.address == 32'd0) ? 32'd0 : seed_q;
				end else begin
					wr_data.counter  = rd_data.counter;
					wr_data.reserved = rd_data.reserved;
				end
			end
			ST_ISSUE: begin
				wr_en            = 1'b1;
				wr_addr          = sel_q;
				wr_data          = rd_data;
				wr_data.counter  = sum[31:0];
				wr_data.reserved = new_res_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q            <= proto_code(sync_word);
			src_q             <= source_id;
			store_ok_q        <= store_ok;
			slot_q            <= SW'(slot);
			entry_q.used      <= entry_in_use;
			entry_q.selector  <= entry_selector;
			entry_q.match     <= entry_match;
			entry_q.address   <= entry_address;
			entry_q.port      <= entry_port;
			entry_q.counter   <= 32'd0;
			entry_q.reserved  <= 32'd0;
			seed_q            <= seed_count;
		end
		cidx_s1 <= idx_q;
		if (chk_s1) begin
			if (hits.node && !found_q.node) begin
				node_idx_q <= cidx_s1;
			end
			if (hits.proto && !found_q.proto) begin
				proto_idx_q <= cidx_s1;
			end
			if (hits.any && !found_q.any) begin
				any_idx_q <= cidx_s1;
			end
		end
		if (state_q == ST_PICK) begin
			sel_q <= best_idx;
		end
		if (state_q == ST_CALC) begin
			new_res_q <= ge ? sum[31:0] : rd_data.reserved;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			chk_s1  <= 1'b0;
			found_q <= '0;
		end else begin
			chk_s1 <= (state_q == ST_SCAN);
			if (chk_s1) begin
				found_q <= found_q | hits;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						found_q <= '0;
						if (action == ACT_UPLINK) begin
							state_q <= ST_SCAN;
						end else if (action == ACT_WRITE && slot_ok) begin
							state_q <= ST_WR_RD;
						end else if (action == ACT_CLEAR && slot_ok) begin
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CLEAR:  state_q <= ST_DONE;
				ST_WR_RD:  state_q <= ST_WR_UPD;
				ST_WR_UPD: state_q <= ST_DONE;
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_SLOT) begin
						state_q <= ST_SCAN_E;
					end
				end
				ST_SCAN_E: state_q <= ST_PICK;
				ST_PICK:   state_q <= any_found ? ST_CALC : ST_DONE;
				ST_CALC: begin
					if (ge && (sum[32] || !store_ok_q)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_DONE;
				ST_DONE:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// result registers: zero at accept, filled in as the uplink proceeds
	always_ff @(posedge clk) begin
		if (accept) begin
			matched         <= 1'b0;
			slot_index      <= 3'd0;
			device_address  <= 32'd0;
			port            <= 8'd0;
			frame_count     <= 32'd0;
			count_status    <= STAT_OK;
			persist_request <= 1'b0;
			persist_value   <= 32'd0;
		end else if (state_q == ST_CALC) begin
			matched        <= 1'b1;
			slot_index     <= 3'(sel_q);
			device_address <= rd_data.address;
			port           <= rd_data.port;
			if (ge) begin
				if (sum[32]) begin
					count_status <= STAT_EXHAUST;
				end else begin
					persist_request <= 1'b1;
					persist_value   <= sum[31:0];
					if (!store_ok_q) begin
						count_status <= STAT_FAIL;
					end
				end
			end
		end else if (state_q == ST_ISSUE) begin
			frame_count  <= rd_data.counter;
			count_status <= STAT_OK;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("done without a transaction in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !matched) |-> (count_status == STAT_OK && !persist_request
			&& frame_count == 32'd0 && device_address == 32'd0))
		else $error("unmatched result carries nonzero fields");

	a_exhaust_no_persist: assert property (@(posedge clk) disable iff (!arst_n)
		(done && count_status == STAT_EXHAUST) |-> (!persist_request && matched))
		else $error("exhausted result requests a reservation write");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import usrfi_pkg::*;

	localparam int SLOTS = 8;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = SLOTS + 5;
	localparam int REPORT_LIMIT = 10;

	localparam logic [1:0] ACT_IGNORED = 2'd3;
	localparam logic [1:0] SEL_NEVER   = 2'd3;
	localparam logic [2:0] REG_RESERVE_BLOCK = 3'd0;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  sync_word;
		logic [31:0] source_id;
		logic        store_ok;
		logic [2:0]  slot;
		logic        entry_in_use;
		logic [1:0]  entry_selector;
		logic [31:0] entry_match;
		logic [31:0] entry_address;
		logic [7:0]  entry_port;
		logic [31:0] seed_count;
	} uplink_cmd_t;

	typedef struct packed {
		logic        matched;
		logic [2:0]  slot_index;
		logic [31:0] device_address;
		logic [7:0]  port;
		logic [31:0] frame_count;
		logic [1:0]  count_status;
		logic        persist_request;
		logic [31:0] persist_value;
	} issue_result_t;

	class fcnt_scoreboard;
		slot_entry_t   slots_tab[SLOTS];
		logic [15:0]   reserve_blk;
		issue_result_t predicted_issues[$];
		int            mismatches;

		function new();
			reserve_blk = RESERVE_BLOCK_RESET;
			mismatches = 0;
			foreach (slots_tab[i]) slots_tab[i] = '0;
		endfunction

		function logic [2:0] sync_to_code(logic [7:0] sw);
			if (sw == SYNC_MESH) return PCODE_MESH;
			if (sw == SYNC_MC) return PCODE_MC;
			if (sw == SYNC_RNS) return PCODE_RNS;
			if (sw == SYNC_LORAWAN) return PCODE_LORAWAN;
			return PCODE_CUSTOM;
		endfunction

		function logic slot_eligible(int s, logic [2:0] code, logic [31:0] src,
				logic [1:0] want);
			slot_entry_t e;
			e = slots_tab[s];
			if (!e.used || e.address == 32'd0 || e.selector != want) return 1'b0;
			case (want)
				SEL_NODE:  return code == PCODE_MESH && src == e.match;
				SEL_PROTO: return {5'd0, code} == e.match[7:0];
				default:   return 1'b1;
			endcase
		endfunction

		// Update the slot table for one accepted transaction and queue its result.
		function void note_transaction(uplink_cmd_t c);
			issue_result_t r;
			logic [2:0]    code;
			logic [1:0]    want;
			logic [31:0]   seed;
			logic [31:0]   cnt;
			logic [32:0]   next_mark;
			logic          issue;
			int            hit;
			r = '0;
			hit = -1;
			case (c.action)
				ACT_WRITE: begin
					if (c.entry_address != slots_tab[c.slot].address) begin
						seed = (c.entry_address == 32'd0) ? 32'd0 : c.seed_count;
						slots_tab[c.slot].counter = seed;
						slots_tab[c.slot].reserved = seed;
					end
					slots_tab[c.slot].used = c.entry_in_use;
					slots_tab[c.slot].selector = c.entry_selector;
					slots_tab[c.slot].match = c.entry_match;
					slots_tab[c.slot].address = c.entry_address;
					slots_tab[c.slot].port = c.entry_port;
				end
				ACT_CLEAR: slots_tab[c.slot] = '0;
				ACT_UPLINK: begin
					code = sync_to_code(c.sync_word);
					// node match wins over protocol match, which wins over catch-all
					for (int p = 0; p < 3 && hit < 0; p++) begin
						want = (p == 0) ? SEL_NODE : (p == 1) ? SEL_PROTO : SEL_ANY;
						for (int s = 0; s < SLOTS && hit < 0; s++)
							if (slot_eligible(s, code, c.source_id, want)) hit = s;
					end
					if (hit >= 0) begin
						r.matched = 1'b1;
						r.slot_index = 3'(hit);
						r.device_address = slots_tab[hit].address;
						r.port = slots_tab[hit].port;
						cnt = slots_tab[hit].counter;
						issue = 1'b1;
						if (cnt >= slots_tab[hit].reserved) begin
							next_mark = {1'b0, cnt} + 33'd1 + {17'd0, reserve_blk};
							if (next_mark[32]) begin
								r.count_status = STAT_EXHAUST;
								issue = 1'b0;
							end else begin
								r.persist_request = 1'b1;
								r.persist_value = next_mark[31:0];
								if (!c.store_ok) begin
									r.count_status = STAT_FAIL;
									issue = 1'b0;
								end else begin
									slots_tab[hit].reserved = next_mark[31:0];
								end
							end
						end
						if (issue) begin
							r.frame_count = cnt;
							r.count_status = STAT_OK;
							slots_tab[hit].counter = cnt + 32'd1;
						end
					end
				end
				default: ;
			endcase
			predicted_issues.push_back(r);
		endfunction

		function string show(issue_result_t r);
			return $sformatf("m=%0d slot=%0d addr=%h port=%h fcnt=%h st=%0d preq=%0d pval=%h",
				r.matched, r.slot_index, r.device_address, r.port, r.frame_count,
				r.count_status, r.persist_request, r.persist_value);
		endfunction

		function void report(string what, issue_result_t want, issue_result_t got);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%t %s: expected %s, got %s", $realtime, what, show(want), show(got));
		endfunction

		function void check_result(issue_result_t got);
			issue_result_t want;
			if (predicted_issues.size() == 0) begin
				report("result with no transaction outstanding", '0, got);
				return;
			end
			want = predicted_issues.pop_front();
			if (got.matched !== want.matched || got.slot_index !== want.slot_index
					|| got.device_address !== want.device_address || got.port !== want.port
					|| got.frame_count !== want.frame_count
					|| got.count_status !== want.count_status
					|| got.persist_request !== want.persist_request
					|| got.persist_value !== want.persist_value)
				report("result mismatch", want, got);
		endfunction

		function void check_drained();
			if (predicted_issues.size() != 0) begin
				mismatches += predicted_issues.size();
				$display("%0d results never arrived", predicted_issues.size());
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = '0;
	logic [7:0]  sync_word = '0;
	logic [31:0] source_id = '0;
	logic        store_ok = 1'b0;
	logic [2:0]  slot = '0;
	logic        entry_in_use = 1'b0;
	logic [1:0]  entry_selector = '0;
	logic [31:0] entry_match = '0;
	logic [31:0] entry_address = '0;
	logic [7:0]  entry_port = '0;
	logic [31:0] seed_count = '0;
	logic        done;
	logic        matched;
	logic [2:0]  slot_index;
	logic [31:0] device_address;
	logic [7:0]  port;
	logic [31:0] frame_count;
	logic [1:0]  count_status;
	logic        persist_request;
	logic [31:0] persist_value;

	fcnt_scoreboard sb = new();
	int idle_pct = 15;
	int quiet_cycles = 0;

	uplink_slot_resolver_fcnt_issuer_unit #(.SLOT_COUNT(SLOTS)) uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles = quiet_cycles + 1;
			if (start && !busy) begin
				sb.note_transaction({action, sync_word, source_id, store_ok, slot, entry_in_use,
					entry_selector, entry_match, entry_address, entry_port, seed_count});
				quiet_cycles = 0;
			end
			if (done) begin
				sb.check_result({matched, slot_index, device_address, port, frame_count,
					count_status, persist_request, persist_value});
				quiet_cycles = 0;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	function automatic uplink_cmd_t noise_cmd();
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return raw[152:0];
	endfunction

	function automatic uplink_cmd_t uplink_cmd(logic [7:0] sw, logic [31:0] src, logic ok);
		uplink_cmd_t c;
		c = noise_cmd();
		c.action = ACT_UPLINK;
		c.sync_word = sw;
		c.source_id = src;
		c.store_ok = ok;
		return c;
	endfunction

	function automatic uplink_cmd_t write_cmd(logic [2:0] s, logic en, logic [1:0] sel,
			logic [31:0] mt, logic [31:0] addr, logic [7:0] pt, logic [31:0] seed);
		uplink_cmd_t c;
		c = noise_cmd();
		c.action = ACT_WRITE;
		c.slot = s;
		c.entry_in_use = en;
		c.entry_selector = sel;
		c.entry_match = mt;
		c.entry_address = addr;
		c.entry_port = pt;
		c.seed_count = seed;
		return c;
	endfunction

	function automatic uplink_cmd_t clear_cmd(logic [2:0] s);
		uplink_cmd_t c;
		c = noise_cmd();
		c.action = ACT_CLEAR;
		c.slot = s;
		return c;
	endfunction

	// Hold the transaction on the inputs until it is taken; drop start at random.
	task automatic send_item(uplink_cmd_t c);
		logic taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			{action, sync_word, source_id, store_ok, slot, entry_in_use, entry_selector,
				entry_match, entry_address, entry_port, seed_count} = c;
			start = ($urandom_range(99) >= idle_pct);
			@(posedge clk);
			taken = start && !busy;
		end
	endtask

	task automatic finish_phase();
		@(negedge clk);
		start = 1'b0;
		while (sb.predicted_issues.size() != 0) @(posedge clk);
	endtask

	task automatic write_reserve_block(logic [15:0] v);
		logic [31:0] readback;
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = REG_RESERVE_BLOCK;
		pwdata = {16'd0, v};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.reserve_blk = v;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (readback !== {16'd0, v}) begin
			sb.mismatches++;
			if (sb.mismatches <= REPORT_LIMIT)
				$display("%t reserve_block readback: expected %h, got %h", $realtime,
					{16'd0, v}, readback);
		end
	endtask

	task automatic run_directed();
		uplink_cmd_t c;
		send_item(uplink_cmd(8'h00, 32'h0, 1'b1));
		c = noise_cmd();
		c.action = ACT_IGNORED;
		send_item(c);
		send_item(write_cmd(3'd0, 1'b1, SEL_ANY, 32'h0, 32'h1, 8'hFF, 32'h0));
		// first uplink on a fresh slot takes a reservation step
		send_item(uplink_cmd(8'hFF, 32'hFFFFFFFF, 1'b1));
		send_item(uplink_cmd(8'h00, 32'h0, 1'b0));
		send_item(write_cmd(3'd1, 1'b1, SEL_NODE, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h00,
			32'hFFFFFFBF));
		send_item(uplink_cmd(SYNC_MESH, 32'hFFFFFFFF, 1'b1));
		// same address again: keep the old counter
		send_item(write_cmd(3'd1, 1'b1, SEL_NODE, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h80, 32'h0));
		send_item(uplink_cmd(SYNC_MESH, 32'hFFFFFFFF, 1'b1));
		send_item(write_cmd(3'd2, 1'b1, SEL_NODE, 32'h0, 32'hA5A5A5A5, 8'h5A, 32'hFFFFFFBE));
		send_item(uplink_cmd(SYNC_MESH, 32'h0, 1'b0));
		send_item(uplink_cmd(SYNC_MESH, 32'h0, 1'b1));
		send_item(uplink_cmd(SYNC_MESH, 32'h0, 1'b1));
		send_item(write_cmd(3'd3, 1'b1, SEL_PROTO, {24'hFFFFFF, 5'd0, PCODE_MC}, 32'h5,
			8'h03, 32'hA));
		send_item(uplink_cmd(SYNC_MC, 32'h0, 1'b1));
		send_item(uplink_cmd(SYNC_RNS, 32'h0, 1'b1));
		send_item(write_cmd(3'd4, 1'b1, SEL_PROTO, {29'd0, PCODE_LORAWAN}, 32'h7, 8'h44,
			32'h20));
		send_item(uplink_cmd(SYNC_LORAWAN, 32'h0, 1'b1));
		// zero address seeds zero and never matches
		send_item(write_cmd(3'd5, 1'b1, SEL_ANY, 32'h0, 32'h0, 8'h11, 32'h1234));
		send_item(write_cmd(3'd6, 1'b0, SEL_ANY, 32'h0, 32'h9, 8'h22, 32'h5));
		send_item(write_cmd(3'd7, 1'b1, SEL_NEVER, 32'h0, 32'h77, 8'h33, 32'h0));
		send_item(clear_cmd(3'd0));
		send_item(uplink_cmd(8'hC3, 32'h1, 1'b1));
		send_item(uplink_cmd(SYNC_MESH, 32'h12345678, 1'b1));
		send_item(clear_cmd(3'd7));
	endtask

	task automatic run_random(int count);
		uplink_cmd_t c;
		int pick;
		int sent;
		sent = 0;
		while (sent < count) begin
			c = noise_cmd();
			pick = $urandom_range(99);
			if (pick < 55) begin
				c.action = ACT_UPLINK;
				case ($urandom_range(5))
					0: c.sync_word = SYNC_MESH;
					1: c.sync_word = SYNC_MC;
					2: c.sync_word = SYNC_RNS;
					3: c.sync_word = SYNC_LORAWAN;
					4: c.sync_word = SYNC_MESH;
					default: ;
				endcase
				if ($urandom_range(2) != 0)
					c.source_id = sb.slots_tab[$urandom_range(SLOTS - 1)].match;
				c.store_ok = ($urandom_range(9) != 0);
			end else if (pick < 85) begin
				c.action = ACT_WRITE;
				c.entry_in_use = ($urandom_range(7) != 0);
				case ($urandom_range(4))
					0: c.entry_match = 32'h0;
					1: c.entry_match = 32'hFFFFFFFF;
					2: c.entry_match = 32'h1F2E3D4C;
					3: c.entry_match[7:0] = 8'($urandom_range(4));
					default: ;
				endcase
				case ($urandom_range(4))
					0: c.entry_address = 32'h0;
					1: c.entry_address = 32'h1;
					2: c.entry_address = 32'hFFFFFFFF;
					default: ;
				endcase
				case ($urandom_range(2))
					0: c.seed_count = $urandom_range(200);
					1: c.seed_count = 32'hFFFFFFFF - $urandom_range(70000);
					default: ;
				endcase
			end else if (pick < 95) begin
				c.action = ACT_CLEAR;
			end else begin
				c.action = ACT_IGNORED;
			end
			send_item(c);
			if (c.action != ACT_IGNORED) sent++;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		finish_phase();
		write_reserve_block(16'd0);
		run_random(134);
		finish_phase();
		idle_pct = 53;
		write_reserve_block(16'hFFFF);
		run_random(133);
		finish_phase();
		idle_pct = 0;
		write_reserve_block(16'($urandom_range(16'hFFFF)));
		run_random(133);
		finish_phase();
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.check_drained();
		if (sb.mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/usrfi_pkg.sv
rtl/usrfi_slot_mem.sv
rtl/usrfi_match_unit.sv
rtl/uplink_slot_resolver_fcnt_issuer_unit.sv
bench/testbench.sv
